[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Request codes, the stored record, the per-cell control word and the
// configuration register map.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // One packet record as held by a cell.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] size;
    logic [31:0] arrival;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  localparam int unsigned CAP_W         = 5;
  localparam int unsigned OCC_OUT_W     = 5;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned REG_CAPACITY  = 0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue of packet records
// A chain of DEPTH cells kept sorted by priority with the head in cell 0.
// Enqueue, dequeue and peek are each processed in the cycle they are accepted.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_stall  req_type, pkt_id, pkt_priority, pkt_size,
//                                 pkt_arrival
//   out      out_valid/ out_stall accepted, found, out_id, out_priority,
//                                 out_size, out_arrival, occupancy_now
//   config   APB (psel..pready)   capacity at byte address 0
//
// Every request is processed in the cycle it is accepted and its word is in
// the output register on the next cycle, one request per cycle sustained
// while out_stall is low. This rests on the compare in each cell and the
// neighbor shift, which all cells perform in parallel.
// Reset clears the occupancy count, the output valid flag and sets capacity
// to 16; the record storage is not cleared, cells above the count are unused.
// While out_stall holds a full output register, in_stall is raised; a word
// taken in the same cycle frees the register for the next request.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           req_type,
  input  logic [15:0]                          pkt_id,
  input  logic [7:0]                           pkt_priority,
  input  logic [31:0]                          pkt_size,
  input  logic [31:0]                          pkt_arrival,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic                                 found,
  output logic [15:0]                          out_id,
  output logic [7:0]                           out_priority,
  output logic [31:0]                          out_size,
  output logic [31:0]                          out_arrival,
  output logic [4:0]                           occupancy_now,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [spq_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [spq_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [spq_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  // Occupancy must hold DEPTH itself; comparisons against the 5-bit capacity
  // register are done at the wider of the two widths.
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > spq_pkg::CAP_W) ? OCC_W : spq_pkg::CAP_W;

  logic [spq_pkg::CAP_W-1:0] capacity;
  logic [OCC_W-1:0]          occupancy;
  logic [OCC_W-1:0]          occupancy_next;

  // Configuration port. The register index is the word address above the
  // byte offset, so a write to any other word is ignored.
  logic cfg_write;
  logic cfg_hit;

  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[spq_pkg::APB_ADDR_W-1:2] == spq_pkg::REG_CAPACITY[0:0]);
  assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata[spq_pkg::CAP_W-1:0] = capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= spq_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[spq_pkg::CAP_W-1:0];
    end
  end

  // Request decode. The enqueue limit is the smaller of capacity and DEPTH.
  logic                in_accept;
  spq_pkg::req_t       req;
  spq_pkg::entry_t     new_entry;
  spq_pkg::cell_ctrl_t ctrl;
  logic                has_room;
  logic                not_empty;
  logic [CMP_W-1:0]    occ_ext;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    limit;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign req       = spq_pkg::req_t'(req_type);

  assign new_entry.id       = pkt_id;
  assign new_entry.prio     = pkt_priority;
  assign new_entry.size     = pkt_size;
  assign new_entry.arrival  = pkt_arrival;

  assign occ_ext   = CMP_W'(occupancy);
  assign cap_ext   = CMP_W'(capacity);
  assign limit     = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
  assign has_room  = occ_ext < limit;
  assign not_empty = (occupancy != '0);

  always_comb begin
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    if (in_accept) begin
      case (req)
        spq_pkg::REQ_ENQUEUE: ctrl.push = has_room;
        spq_pkg::REQ_DEQUEUE: ctrl.pop  = not_empty;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    occupancy_next = occupancy;
    if (ctrl.push) begin
      occupancy_next = occupancy + OCC_W'(1);
    end else if (ctrl.pop) begin
      occupancy_next = occupancy - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // The cell chain. A cell is in use when its index is below the count, so
  // the records kept in place form a prefix and the new record lands in the
  // first cell that does not keep; cells beyond it shift one place toward
  // the tail. A dequeue shifts every cell one place toward the head.
  spq_pkg::entry_t entries [DEPTH];
  logic [DEPTH-1:0] keeps;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            used;
    logic            left_keep;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    assign used = (CMP_W'(i) < occ_ext);

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = keeps[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .used        (used),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .new_entry   (new_entry),
      .keep        (keeps[i]),
      .entry       (entries[i])
    );
  end

  // Result word. The head fields read zero unless a head is returned.
  logic                        head_found;
  logic [CMP_W-1:0]            occ_next_ext;

  assign head_found   = not_empty && ((req == spq_pkg::REQ_DEQUEUE) ||
                                      (req == spq_pkg::REQ_PEEK));
  assign occ_next_ext = CMP_W'(occupancy_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      accepted      <= ctrl.push;
      found         <= head_found;
      out_id        <= head_found ? entries[0].id       : '0;
      out_priority  <= head_found ? entries[0].prio     : '0;
      out_size      <= head_found ? entries[0].size     : '0;
      out_arrival   <= head_found ? entries[0].arrival  : '0;
      occupancy_now <= occ_next_ext[spq_pkg::OCC_OUT_W-1:0];
    end
  end

endmodule

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted chain
// Holds one record, compares its priority against the incoming one and
// either keeps its record, takes the new one, or takes a neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                used,
  input  logic                left_keep,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  input  spq_pkg::entry_t     new_entry,
  output logic                keep,
  output spq_pkg::entry_t     entry
);

  // An occupied cell whose priority is equal or more urgent stays put, so
  // equal priorities keep their arrival order.
  assign keep = used && (entry.prio <= new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.push && !keep) begin
      if (left_keep) begin
        entry <= new_entry;
      end else begin
        entry <= left_entry;
      end
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

[tb/sv/stable_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking testbench of the priority queue
// A short directed table, a fill, then ten random phases at capacity settings
// from a list, each word checked against a typed word or the bench queue.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 175;
  localparam int FILL_ITEMS  = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  // One packet record as the bench keeps it.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] size;
    logic [31:0] arrival;
  } pkt_rec_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] size;
    logic [31:0] arrival;
    logic [4:0]  occ;
  } sched_word_t;

  // A row of the directed table. When typed_ok is set, the word in typed is
  // what the block must answer; otherwise the bench queue decides.
  typedef struct packed {
    spq_pkg::req_t req;
    pkt_rec_t      rec;
    logic          typed_ok;
    sched_word_t   typed;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     req_type = 2'd0;
  logic [15:0]                    pkt_id = 16'd0;
  logic [7:0]                     pkt_priority = 8'd0;
  logic [31:0]                    pkt_size = 32'd0;
  logic [31:0]                    pkt_arrival = 32'd0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           accepted;
  logic                           found;
  logic [15:0]                    out_id;
  logic [7:0]                     out_priority;
  logic [31:0]                    out_size;
  logic [31:0]                    out_arrival;
  logic [4:0]                     occupancy_now;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [spq_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [spq_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [spq_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Bench copy of the queue: records sorted with the head at index 0, the
  // count of records held and the capacity register as last written.
  pkt_rec_t    held [DEPTH];
  int          held_cnt = 0;
  logic [4:0]  cap_reg = spq_pkg::CAPACITY_RESET;

  sched_word_t pending_words [$];
  int          mismatches = 0;
  int          cycle_count = 0;

  // Idling control shared by both sides, and the receiver hold-off request.
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  plan_row_t   plan [18];
  logic [4:0]  phase_cap [PHASES] = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd16,
                                      5'd8, 5'd2, 5'd16, 5'd17, 5'd16};

  stable_priority_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .pkt_id(pkt_id),
    .pkt_priority(pkt_priority),
    .pkt_size(pkt_size),
    .pkt_arrival(pkt_arrival),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .accepted(accepted),
    .found(found),
    .out_id(out_id),
    .out_priority(out_priority),
    .out_size(out_size),
    .out_arrival(out_arrival),
    .occupancy_now(occupancy_now),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // The run is ended here if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch on %s at cycle %0d: got %0h, want %0h",
             what, cycle_count, got, want);
  endtask

  // Applies one request to the bench queue and returns the word the block
  // must produce for it. A new record goes behind every record of equal or
  // more urgent priority, which keeps ties in arrival order. The enqueue
  // limit is the smaller of the capacity register and the depth, so a
  // capacity lowered under the current count simply refuses enqueues.
  function automatic sched_word_t serve_request(input spq_pkg::req_t req,
                                                input pkt_rec_t rec);
    sched_word_t w;
    int          limit;
    int          pos;
    int          k;
    w = '0;
    limit = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
    case (req)
      spq_pkg::REQ_ENQUEUE: begin
        if (held_cnt < limit) begin
          pos = 0;
          while (pos < held_cnt && held[pos].prio <= rec.prio)
            pos++;
          for (k = held_cnt; k > pos; k--)
            held[k] = held[k-1];
          held[pos] = rec;
          held_cnt++;
          w.accepted = 1'b1;
        end
      end
      spq_pkg::REQ_DEQUEUE, spq_pkg::REQ_PEEK: begin
        // An empty queue answers not found with all head fields at zero.
        if (held_cnt > 0) begin
          w.found   = 1'b1;
          w.id      = held[0].id;
          w.prio    = held[0].prio;
          w.size    = held[0].size;
          w.arrival = held[0].arrival;
          if (req == spq_pkg::REQ_DEQUEUE) begin
            for (k = 0; k + 1 < held_cnt; k++)
              held[k] = held[k+1];
            held_cnt--;
          end
        end
      end
      default: ;  // the unused code does nothing
    endcase
    w.occ = 5'(held_cnt);
    return w;
  endfunction

  // Offers one word on the input channel and holds it until it is taken.
  // A random gap may come first; once valid is up, it stays up with the
  // payload frozen until the block accepts the word.
  task automatic send_word(input spq_pkg::req_t req, input pkt_rec_t rec,
                           input logic typed_ok, input sched_word_t typed);
    sched_word_t want;
    if (idle_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    pkt_id       <= rec.id;
    pkt_priority <= rec.prio;
    pkt_size     <= rec.size;
    pkt_arrival  <= rec.arrival;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = serve_request(req, rec);
    pending_words.push_back(typed_ok ? typed : want);
  endtask

  // Lowers valid and waits until every expected word has come back. Each
  // request yields exactly one word, so the block is idle at that point.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Writes the capacity register over the config bus, then reads it back.
  // psel stays up across both transfers so no signal is assigned twice in
  // one step.
  task automatic set_capacity(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= spq_pkg::APB_ADDR_W'(4 * spq_pkg::REG_CAPACITY);
    pwdata  <= spq_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== spq_pkg::APB_DATA_W'(value))
      report_mismatch("capacity read back", prdata, spq_pkg::APB_DATA_W'(value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Half of the priorities come from a narrow band so that ties are common.
  function automatic pkt_rec_t random_record();
    pkt_rec_t r;
    r.id      = 16'($urandom);
    r.prio    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom);
    r.size    = $urandom;
    r.arrival = $urandom;
    return r;
  endfunction

  // Receiver side: random stalls, none while idling is off, and a long
  // hold-off on request so that the output word sits and the input backs up.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 34);
    end
  end

  // Output checker: every word taken is compared with the oldest pending
  // expectation, field by field.
  always @(posedge clk) begin
    sched_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(occupancy_now), 32'd0);
      end else begin
        want = pending_words.pop_front();
        if (accepted !== want.accepted)
          report_mismatch("accepted", 32'(accepted), 32'(want.accepted));
        if (found !== want.found)
          report_mismatch("found", 32'(found), 32'(want.found));
        if (out_id !== want.id)
          report_mismatch("out_id", 32'(out_id), 32'(want.id));
        if (out_priority !== want.prio)
          report_mismatch("out_priority", 32'(out_priority), 32'(want.prio));
        if (out_size !== want.size)
          report_mismatch("out_size", out_size, want.size);
        if (out_arrival !== want.arrival)
          report_mismatch("out_arrival", out_arrival, want.arrival);
        if (occupancy_now !== want.occ)
          report_mismatch("occupancy_now", 32'(occupancy_now), 32'(want.occ));
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin
    int            ph;
    int            n;
    int            enq_pct;
    int            pick;
    spq_pkg::req_t req;
    sched_word_t   none;

    none = '0;

    // Directed table. Rows with a typed word cover the empty queue, the
    // unused request code and the extreme field values; the rest, with the
    // ties at priority 0x80 and the record slipping in ahead of them, are
    // left to the bench queue.
    plan = '{
      '{spq_pkg::REQ_PEEK,    '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd0}},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd0}},
      '{spq_pkg::REQ_NONE,    '{16'hffff, 8'hff, 32'hffffffff, 32'hffffffff}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd0}},
      '{spq_pkg::REQ_ENQUEUE, '{16'hffff, 8'hff, 32'hffffffff, 32'hffffffff}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd1}},
      '{spq_pkg::REQ_ENQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b1,
        '{1'b1, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd2}},
      '{spq_pkg::REQ_PEEK,    '{16'h5a5a, 8'h33, 32'h1234, 32'h5678}, 1'b1,
        '{1'b0, 1'b1, 16'h0, 8'h0, 32'h0, 32'h0, 5'd2}},
      '{spq_pkg::REQ_ENQUEUE, '{16'h0001, 8'h80, 32'h0000_0100, 32'h10}, 1'b0, none},
      '{spq_pkg::REQ_ENQUEUE, '{16'h0002, 8'h80, 32'h0000_0280, 32'h11}, 1'b0, none},
      '{spq_pkg::REQ_ENQUEUE, '{16'h0003, 8'h7f, 32'h8000_0001, 32'h12}, 1'b0, none},
      '{spq_pkg::REQ_ENQUEUE, '{16'h0004, 8'h80, 32'h0000_00ff, 32'h13}, 1'b0, none},
      '{spq_pkg::REQ_NONE,    '{16'h1234, 8'h01, 32'haaaa_5555, 32'h5555_aaaa}, 1'b1,
        '{1'b0, 1'b0, 16'h0, 8'h0, 32'h0, 32'h0, 5'd6}},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_PEEK,    '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none},
      '{spq_pkg::REQ_DEQUEUE, '{16'h0, 8'h0, 32'h0, 32'h0}, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_capacity(5'd16);
    foreach (plan[i])
      send_word(plan[i].req, plan[i].rec, plan[i].typed_ok, plan[i].typed);
    wait_drained();

    // Fill well past the first capacity setting, so that the next write
    // lowers the capacity under the number of records already held.
    for (n = 0; n < FILL_ITEMS; n++)
      send_word(spq_pkg::REQ_ENQUEUE, random_record(), 1'b0, none);
    wait_drained();

    // Random phases. Even phases lean toward enqueues and fill the queue,
    // odd ones drain it. Phase 2 starts with a long receiver hold-off and
    // phase 4 runs with no idling on either side.
    for (ph = 0; ph < PHASES; ph++) begin
      set_capacity(phase_cap[ph]);
      idle_on = (ph != 4);
      if (ph == 2)
        hold_req = 1'b1;
      enq_pct = (ph % 2 == 0) ? 60 : 35;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_pct)
          req = spq_pkg::REQ_ENQUEUE;
        else if (pick < 85)
          req = spq_pkg::REQ_DEQUEUE;
        else if (pick < 96)
          req = spq_pkg::REQ_PEEK;
        else
          req = spq_pkg::REQ_NONE;
        send_word(req, random_record(), 1'b0, none);
      end
      wait_drained();
    end
    idle_on = 1'b1;

    // A few quiet cycles so that any stray word would still be caught.
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("PASS stable_priority_queue");
    else
      $display("FAIL stable_priority_queue");
    $finish;
  end

endmodule

[filelist.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/sv/stable_priority_queue_tb.sv
